FILE: rtl/tlpw_pkg.sv
// ----------------------------------------------------------------------------
// tlpw_pkg
// shared types, character codes and helpers for the telemetry line parser
// with link watchdog
// ----------------------------------------------------------------------------
package tlpw_pkg;

  // fixed field widths
  localparam int RPM_W     = 21;
  localparam int VBAT_W    = 31;
  localparam int FAULT_W   = 21;
  localparam int TIMEOUT_W = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;

  // command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // result kinds
  localparam logic KIND_TELEM = 1'b0;
  localparam logic KIND_STALE = 1'b1;

  localparam logic signed [FAULT_W-1:0] STALE_FAULT = 21'sd1;

  // character codes
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_T     = 8'h54;

  // position within a line
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_T,
    PH_E,
    PH_L,
    PH_RPM,
    PH_VBAT,
    PH_ERR,
    PH_CHECK
  } phase_t;

  // position within one number
  typedef enum logic [2:0] {
    NS_PRE,
    NS_SIGN,
    NS_INT,
    NS_FRAC,
    NS_TRAIL
  } num_stage_t;

  // finished line from the scanner
  typedef struct packed {
    logic                       ok;
    logic signed [RPM_W-1:0]    rpm;
    logic signed [VBAT_W-1:0]   vbat_milli;
    logic signed [FAULT_W-1:0]  fault_code;
  } frame_t;

  // result offered to the output register
  typedef struct packed {
    logic                       valid;
    logic                       kind;
    logic signed [RPM_W-1:0]    rpm;
    logic signed [VBAT_W-1:0]   vbat_milli;
    logic signed [FAULT_W-1:0]  fault_code;
    logic                       connected;
    logic                       link_changed;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  // power of ten, constant arguments only
  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < 18; i++) begin
      if (i < n) p = p * 10;
    end
    return p;
  endfunction

endpackage

FILE: rtl/tlpw_line_scan.sv
// ----------------------------------------------------------------------------
// tlpw_line_scan
// per-byte line scanner: tracks the frame text, accumulates the number
// fields and evaluates the checksum when the line feed arrives
// ----------------------------------------------------------------------------
module tlpw_line_scan #(
  parameter int MAX_DIGITS  = 6,
  parameter int FRAC_DIGITS = 3,
  parameter int MAX_LINE    = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              cmd,
  input  logic [7:0]        data_byte,
  output tlpw_pkg::frame_t  frame
);

  localparam int ACC_W  = $clog2(10 ** MAX_DIGITS);
  localparam int FRAC_W = (FRAC_DIGITS > 0) ? $clog2(10 ** FRAC_DIGITS) : 1;
  localparam int DC_W   = $clog2(MAX_DIGITS + 1);
  localparam int FC_W   = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
  localparam int NW     = (FRAC_DIGITS > 0) ? FRAC_DIGITS : 1;
  localparam int IX_W   = (NW > 1) ? $clog2(NW) : 1;
  localparam int LEN_W  = $clog2(MAX_LINE + 2);
  localparam int SUM_W  = (ACC_W + 3 > 9) ? ACC_W + 3 : 9;
  localparam int CMP_W  = (ACC_W > 8) ? ACC_W : 8;
  localparam int VB_W   = tlpw_pkg::VBAT_W;
  localparam logic [VB_W-1:0] P10F = VB_W'(10 ** FRAC_DIGITS);

  // line state
  tlpw_pkg::phase_t     phase, phase_next;
  tlpw_pkg::num_stage_t num_stage, num_stage_next;
  logic                 line_bad, line_bad_next;
  logic [ACC_W-1:0]     speed_acc, speed_acc_next;
  logic [ACC_W-1:0]     volt_int_acc, volt_int_acc_next;
  logic [FRAC_W-1:0]    volt_frac_acc, volt_frac_acc_next;
  logic [ACC_W-1:0]     fault_acc, fault_acc_next;
  logic [ACC_W-1:0]     check_acc, check_acc_next;
  logic [3:0]           sign_flags, sign_flags_next;
  logic [DC_W-1:0]      digit_count, digit_count_next;
  logic [FC_W-1:0]      frac_count, frac_count_next;
  logic                 has_digit, has_digit_next;
  logic                 chk_text, chk_text_next;
  logic                 chk_junk, chk_junk_next;
  logic                 chk_big, chk_big_next;
  logic [LEN_W-1:0]     line_length, line_length_next;

  // byte decode
  logic             is_byte, eol, ws, is_digit, bad_now;
  logic [3:0]       digit;
  logic [7:0]       term;
  logic [1:0]       fsel;
  logic [ACC_W-1:0] acc_cur;
  logic [LEN_W-1:0] len_inc;

  // number character step
  tlpw_pkg::num_stage_t nc_stage;
  logic [ACC_W-1:0]     nc_acc;
  logic [DC_W-1:0]      nc_dc;
  logic [FC_W-1:0]      nc_fc;
  logic [FRAC_W-1:0]    nc_frac;
  logic                 nc_hd;
  logic [3:0]           nc_sign;
  logic                 nc_inv, nc_big;

  logic [FRAC_W-1:0] frac_wt [NW];

  for (genvar gi = 0; gi < NW; gi++) begin : g_wt
    assign frac_wt[gi] = FRAC_W'(tlpw_pkg::pow10(FRAC_DIGITS - 1 - gi));
  end

  assign is_byte  = step && (cmd == tlpw_pkg::CMD_BYTE);
  assign eol      = (data_byte == tlpw_pkg::CHAR_LF);
  assign ws       = tlpw_pkg::is_ws(data_byte);
  assign is_digit = (data_byte >= tlpw_pkg::CHAR_0) && (data_byte <= tlpw_pkg::CHAR_9);
  assign digit    = 4'(data_byte - tlpw_pkg::CHAR_0);
  assign term     = (phase == tlpw_pkg::PH_ERR) ? tlpw_pkg::CHAR_SEMI : tlpw_pkg::CHAR_COMMA;
  assign len_inc  = (line_length <= LEN_W'(MAX_LINE)) ? line_length + 1'b1 : line_length;
  assign bad_now  = line_bad || (len_inc > LEN_W'(MAX_LINE));

  always_comb begin
    case (phase)
      tlpw_pkg::PH_RPM:  fsel = 2'd0;
      tlpw_pkg::PH_VBAT: fsel = 2'd1;
      tlpw_pkg::PH_ERR:  fsel = 2'd2;
      default:           fsel = 2'd3;
    endcase
  end

  always_comb begin
    case (fsel)
      2'd0:    acc_cur = speed_acc;
      2'd1:    acc_cur = volt_int_acc;
      2'd2:    acc_cur = fault_acc;
      default: acc_cur = check_acc;
    endcase
  end

  // one character of a signed decimal
  always_comb begin
    nc_stage = num_stage;
    nc_acc   = acc_cur;
    nc_dc    = digit_count;
    nc_fc    = frac_count;
    nc_frac  = volt_frac_acc;
    nc_hd    = has_digit;
    nc_sign  = sign_flags;
    nc_inv   = 1'b0;
    nc_big   = 1'b0;
    if (ws) begin
      if (num_stage == tlpw_pkg::NS_SIGN) begin
        nc_inv = 1'b1;
      end else if (num_stage == tlpw_pkg::NS_INT || num_stage == tlpw_pkg::NS_FRAC) begin
        nc_stage = tlpw_pkg::NS_TRAIL;
      end
    end else if (is_digit) begin
      if (num_stage == tlpw_pkg::NS_TRAIL) begin
        nc_inv = 1'b1;
      end else begin
        nc_hd = 1'b1;
        if (num_stage == tlpw_pkg::NS_FRAC) begin
          if (frac_count < FC_W'(FRAC_DIGITS)) begin
            nc_frac = volt_frac_acc + FRAC_W'(digit) * frac_wt[frac_count[IX_W-1:0]];
            nc_fc   = frac_count + 1'b1;
          end
        end else begin
          nc_stage = tlpw_pkg::NS_INT;
          // leading zeros do not count
          if (!(acc_cur == '0 && digit == 4'd0)) begin
            if (digit_count >= DC_W'(MAX_DIGITS)) begin
              nc_big = 1'b1;
            end else begin
              nc_acc = acc_cur * ACC_W'(10) + ACC_W'(digit);
              nc_dc  = digit_count + 1'b1;
            end
          end
        end
      end
    end else if (data_byte == tlpw_pkg::CHAR_PLUS || data_byte == tlpw_pkg::CHAR_MINUS) begin
      if (num_stage != tlpw_pkg::NS_PRE) begin
        nc_inv = 1'b1;
      end else begin
        nc_stage = tlpw_pkg::NS_SIGN;
        if (data_byte == tlpw_pkg::CHAR_MINUS) nc_sign[fsel] = 1'b1;
      end
    end else if (data_byte == tlpw_pkg::CHAR_DOT && phase == tlpw_pkg::PH_VBAT &&
                 (num_stage == tlpw_pkg::NS_PRE || num_stage == tlpw_pkg::NS_SIGN ||
                  num_stage == tlpw_pkg::NS_INT)) begin
      nc_stage = tlpw_pkg::NS_FRAC;
    end else begin
      nc_inv = 1'b1;
    end
  end

  // next line position
  always_comb begin
    phase_next = phase;
    if (is_byte) begin
      if (eol) begin
        phase_next = tlpw_pkg::PH_LEAD;
      end else if (!bad_now) begin
        case (phase)
          tlpw_pkg::PH_LEAD: if (data_byte == tlpw_pkg::CHAR_T) phase_next = tlpw_pkg::PH_T;
          tlpw_pkg::PH_T:    if (data_byte == tlpw_pkg::CHAR_E) phase_next = tlpw_pkg::PH_E;
          tlpw_pkg::PH_E:    if (data_byte == tlpw_pkg::CHAR_L) phase_next = tlpw_pkg::PH_L;
          tlpw_pkg::PH_L:    if (data_byte == tlpw_pkg::CHAR_COMMA) phase_next = tlpw_pkg::PH_RPM;
          tlpw_pkg::PH_RPM:  if (data_byte == term && has_digit) phase_next = tlpw_pkg::PH_VBAT;
          tlpw_pkg::PH_VBAT: if (data_byte == term && has_digit) phase_next = tlpw_pkg::PH_ERR;
          tlpw_pkg::PH_ERR:  if (data_byte == term && has_digit) phase_next = tlpw_pkg::PH_CHECK;
          default: ;
        endcase
      end
    end
  end

  // field and status updates
  always_comb begin
    num_stage_next     = num_stage;
    line_bad_next      = line_bad;
    speed_acc_next     = speed_acc;
    volt_int_acc_next  = volt_int_acc;
    volt_frac_acc_next = volt_frac_acc;
    fault_acc_next     = fault_acc;
    check_acc_next     = check_acc;
    sign_flags_next    = sign_flags;
    digit_count_next   = digit_count;
    frac_count_next    = frac_count;
    has_digit_next     = has_digit;
    chk_text_next      = chk_text;
    chk_junk_next      = chk_junk;
    chk_big_next       = chk_big;
    line_length_next   = line_length;
    if (is_byte && eol) begin
      num_stage_next     = tlpw_pkg::NS_PRE;
      line_bad_next      = 1'b0;
      speed_acc_next     = '0;
      volt_int_acc_next  = '0;
      volt_frac_acc_next = '0;
      fault_acc_next     = '0;
      check_acc_next     = '0;
      sign_flags_next    = '0;
      digit_count_next   = '0;
      frac_count_next    = '0;
      has_digit_next     = 1'b0;
      chk_text_next      = 1'b0;
      chk_junk_next      = 1'b0;
      chk_big_next       = 1'b0;
      line_length_next   = '0;
    end else if (is_byte) begin
      line_length_next = len_inc;
      if (bad_now) begin
        line_bad_next = 1'b1;
      end else begin
        case (phase)
          tlpw_pkg::PH_LEAD: if (!ws && data_byte != tlpw_pkg::CHAR_T) line_bad_next = 1'b1;
          tlpw_pkg::PH_T:    if (data_byte != tlpw_pkg::CHAR_E) line_bad_next = 1'b1;
          tlpw_pkg::PH_E:    if (data_byte != tlpw_pkg::CHAR_L) line_bad_next = 1'b1;
          tlpw_pkg::PH_L:    if (data_byte != tlpw_pkg::CHAR_COMMA) line_bad_next = 1'b1;
          tlpw_pkg::PH_RPM, tlpw_pkg::PH_VBAT, tlpw_pkg::PH_ERR: begin
            if (data_byte == term) begin
              if (!has_digit) begin
                line_bad_next = 1'b1;
              end else begin
                num_stage_next   = tlpw_pkg::NS_PRE;
                has_digit_next   = 1'b0;
                digit_count_next = '0;
              end
            end else begin
              if (nc_inv || nc_big) line_bad_next = 1'b1;
              num_stage_next     = nc_stage;
              has_digit_next     = nc_hd;
              digit_count_next   = nc_dc;
              frac_count_next    = nc_fc;
              volt_frac_acc_next = nc_frac;
              sign_flags_next    = nc_sign;
              case (phase)
                tlpw_pkg::PH_RPM:  speed_acc_next    = nc_acc;
                tlpw_pkg::PH_VBAT: volt_int_acc_next = nc_acc;
                default:           fault_acc_next    = nc_acc;
              endcase
            end
          end
          default: begin
            // checksum text
            if (data_byte == tlpw_pkg::CHAR_SEMI) begin
              line_bad_next = 1'b1;
            end else begin
              if (!ws) chk_text_next = 1'b1;
              if (!chk_junk) begin
                num_stage_next   = nc_stage;
                has_digit_next   = nc_hd;
                digit_count_next = nc_dc;
                sign_flags_next  = nc_sign;
                check_acc_next   = nc_acc;
                if (nc_inv) chk_junk_next = 1'b1;
                if (nc_big) chk_big_next = 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= tlpw_pkg::PH_LEAD;
      num_stage     <= tlpw_pkg::NS_PRE;
      line_bad      <= 1'b0;
      speed_acc     <= '0;
      volt_int_acc  <= '0;
      volt_frac_acc <= '0;
      fault_acc     <= '0;
      check_acc     <= '0;
      sign_flags    <= '0;
      digit_count   <= '0;
      frac_count    <= '0;
      has_digit     <= 1'b0;
      chk_text      <= 1'b0;
      chk_junk      <= 1'b0;
      chk_big       <= 1'b0;
      line_length   <= '0;
    end else begin
      phase         <= phase_next;
      num_stage     <= num_stage_next;
      line_bad      <= line_bad_next;
      speed_acc     <= speed_acc_next;
      volt_int_acc  <= volt_int_acc_next;
      volt_frac_acc <= volt_frac_acc_next;
      fault_acc     <= fault_acc_next;
      check_acc     <= check_acc_next;
      sign_flags    <= sign_flags_next;
      digit_count   <= digit_count_next;
      frac_count    <= frac_count_next;
      has_digit     <= has_digit_next;
      chk_text      <= chk_text_next;
      chk_junk      <= chk_junk_next;
      chk_big       <= chk_big_next;
      line_length   <= line_length_next;
    end
  end

  // end of line evaluation
  logic [SUM_W-1:0] s_rpm, s_vint, s_err, csum;
  logic [7:0]       sum_lo, sum_mag;
  logic             sum_neg, chk_ok, line_ok;
  logic [VB_W-1:0]  vmag;

  assign s_rpm  = sign_flags[0] ? SUM_W'(0) - SUM_W'(speed_acc) : SUM_W'(speed_acc);
  assign s_vint = sign_flags[1] ? SUM_W'(0) - SUM_W'(volt_int_acc) : SUM_W'(volt_int_acc);
  assign s_err  = sign_flags[2] ? SUM_W'(0) - SUM_W'(fault_acc) : SUM_W'(fault_acc);
  assign csum   = s_rpm + s_vint + s_err;

  // remainder keeps the sign of the sum: compare magnitude and sign separately
  assign sum_neg = csum[SUM_W-1];
  assign sum_lo  = csum[7:0];
  assign sum_mag = sum_neg ? 8'd0 - sum_lo : sum_lo;

  always_comb begin
    if (!chk_text) begin
      chk_ok = 1'b1;
    end else if (chk_junk || !has_digit) begin
      chk_ok = (sum_mag == 8'd0);
    end else if (chk_big) begin
      chk_ok = 1'b0;
    end else if (sum_mag == 8'd0) begin
      chk_ok = (check_acc == '0);
    end else begin
      chk_ok = (CMP_W'(check_acc) == CMP_W'(sum_mag)) && (sign_flags[3] == sum_neg);
    end
  end

  assign line_ok = !line_bad && (line_length <= LEN_W'(MAX_LINE)) &&
                   (phase == tlpw_pkg::PH_CHECK);
  assign vmag    = VB_W'(volt_int_acc) * P10F + VB_W'(volt_frac_acc);

  assign frame.ok         = is_byte && eol && line_ok && chk_ok;
  assign frame.rpm        = sign_flags[0] ? tlpw_pkg::RPM_W'(0) - tlpw_pkg::RPM_W'(speed_acc)
                                          : tlpw_pkg::RPM_W'(speed_acc);
  assign frame.vbat_milli = sign_flags[1] ? VB_W'(0) - vmag : vmag;
  assign frame.fault_code = sign_flags[2] ? tlpw_pkg::FAULT_W'(0) - tlpw_pkg::FAULT_W'(fault_acc)
                                          : tlpw_pkg::FAULT_W'(fault_acc);

endmodule

FILE: rtl/tlpw_watchdog.sv
// ----------------------------------------------------------------------------
// tlpw_watchdog
// tick counter with programmable timeout, link flag and result selection
// ----------------------------------------------------------------------------
module tlpw_watchdog (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic                             cmd,
  input  logic                             cfg_wr_en,
  input  logic [tlpw_pkg::TIMEOUT_W-1:0]   cfg_wr_data,
  input  tlpw_pkg::frame_t                 frame,
  output tlpw_pkg::result_t                result
);

  logic [tlpw_pkg::TIMEOUT_W-1:0] timeout_ticks;
  logic [tlpw_pkg::TIMEOUT_W-1:0] tick_count, tick_count_next;
  logic [tlpw_pkg::TIMEOUT_W-1:0] cnt_inc;
  logic                           link_up, link_up_next;
  logic                           is_tick, stale;

  assign is_tick = step && (cmd == tlpw_pkg::CMD_TICK);
  // any timeout fires once the incremented count reaches all ones, so the
  // count stays below that and the increment cannot wrap
  assign cnt_inc = tick_count + 1'b1;
  assign stale   = is_tick && !(cnt_inc < timeout_ticks);

  always_comb begin
    tick_count_next = tick_count;
    link_up_next    = link_up;
    if (frame.ok) begin
      tick_count_next = '0;
      link_up_next    = 1'b1;
    end else if (stale) begin
      tick_count_next = '0;
      link_up_next    = 1'b0;
    end else if (is_tick) begin
      tick_count_next = cnt_inc;
    end
  end

  always_comb begin
    result.valid        = frame.ok || stale;
    result.kind         = stale ? tlpw_pkg::KIND_STALE : tlpw_pkg::KIND_TELEM;
    result.rpm          = stale ? '0 : frame.rpm;
    result.vbat_milli   = stale ? '0 : frame.vbat_milli;
    result.fault_code   = stale ? tlpw_pkg::STALE_FAULT : frame.fault_code;
    result.connected    = !stale;
    result.link_changed = stale ? link_up : !link_up;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= tlpw_pkg::TIMEOUT_RESET;
      tick_count    <= '0;
      link_up       <= 1'b0;
    end else begin
      if (cfg_wr_en) timeout_ticks <= cfg_wr_data;
      tick_count <= tick_count_next;
      link_up    <= link_up_next;
    end
  end

endmodule

FILE: rtl/telemetry_line_parser_watchdog_unit.sv
// ----------------------------------------------------------------------------
// telemetry_line_parser_watchdog_unit
// parses "TEL,rpm,vbat,error;checksum" lines from a byte stream and keeps a
// tick-driven link watchdog
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   -------   ---------  ---------------------  ----------------------------
//   input     in         in_valid / in_ready    cmd, data_byte
//   result    out        out_valid / out_ready  kind, rpm, vbat_milli,
//                                               fault_code, connected,
//                                               link_changed
//   config    in         cfg_wr_en              cfg_wr_data (timeout_ticks)
//
// one input transfer per cycle sustained while results drain; an input
// that yields a result passes the input register, then the result register,
// before the result is shown; a shown result then waits for out_ready
// the per-byte scanner update and end-of-line checksum form the single stage
// between the two registers
// rst is synchronous: line state, tick counter and link flag clear, the
// timeout goes back to 500
// a held result only stalls the input side when the input register also
// holds an item; in_ready stays high whenever the result register can drain
// ----------------------------------------------------------------------------
module telemetry_line_parser_watchdog_unit #(
  parameter int MAX_DIGITS  = 6,
  parameter int FRAC_DIGITS = 3,
  parameter int MAX_LINE    = 128
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    cmd,
  input  logic [7:0]                              data_byte,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    kind,
  output logic signed [tlpw_pkg::RPM_W-1:0]       rpm,
  output logic signed [tlpw_pkg::VBAT_W-1:0]      vbat_milli,
  output logic signed [tlpw_pkg::FAULT_W-1:0]     fault_code,
  output logic                                    connected,
  output logic                                    link_changed,
  // configuration
  input  logic                                    cfg_wr_en,
  input  logic [tlpw_pkg::TIMEOUT_W-1:0]          cfg_wr_data
);

  // input register
  logic       in_held;
  logic       cmd_q;
  logic [7:0] byte_q;
  logic       in_xfer;
  logic       advance;

  tlpw_pkg::frame_t  frame;
  tlpw_pkg::result_t result;

  // the held item moves on when the result register is free or draining
  assign advance  = in_held && (!out_valid || out_ready);
  assign in_ready = !in_held || advance;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_xfer) begin
      in_held <= 1'b1;
    end else if (advance) begin
      in_held <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_q  <= cmd;
      byte_q <= data_byte;
    end
  end

  // line scanner: frame text, number fields, checksum
  tlpw_line_scan #(
    .MAX_DIGITS  (MAX_DIGITS),
    .FRAC_DIGITS (FRAC_DIGITS),
    .MAX_LINE    (MAX_LINE)
  ) u_line_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .cmd       (cmd_q),
    .data_byte (byte_q),
    .frame     (frame)
  );

  // watchdog and result selection
  tlpw_watchdog u_watchdog (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .cmd         (cmd_q),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .frame       (frame),
    .result      (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      kind         <= result.kind;
      rpm          <= result.rpm;
      vbat_milli   <= result.vbat_milli;
      fault_code   <= result.fault_code;
      connected    <= result.connected;
      link_changed <= result.link_changed;
    end
  end

endmodule

FILE: rtl/tlpw_checker.sv
// ----------------------------------------------------------------------------
// tlpw_checker
// port-level checks for the telemetry parser, bound to the top level
// ----------------------------------------------------------------------------
module tlpw_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                kind,
  input logic signed [tlpw_pkg::RPM_W-1:0]   rpm,
  input logic signed [tlpw_pkg::VBAT_W-1:0]  vbat_milli,
  input logic signed [tlpw_pkg::FAULT_W-1:0] fault_code,
  input logic                                connected,
  input logic                                link_changed
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(rpm) &&
      $stable(vbat_milli) && $stable(fault_code) && $stable(connected) &&
      $stable(link_changed))
    else $error("result changed while stalled");

  // stale report carries fixed fields and drops the link
  a_stale_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == tlpw_pkg::KIND_STALE |->
      rpm == '0 && vbat_milli == '0 && fault_code == tlpw_pkg::STALE_FAULT && !connected)
    else $error("bad stale report");

  // good frame always leaves the link up
  a_telem_link: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == tlpw_pkg::KIND_TELEM |-> connected)
    else $error("telemetry without link");

  // input side only stalls behind a held result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free result slot");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind telemetry_line_parser_watchdog_unit tlpw_checker u_tlpw_checker (.*);
